@@ hw/rtl/matrix_crosstalk_compensation_unit_macros.svh @@
// Assertion macros shared by the RTL of the crosstalk compensation unit.
// Each use expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef MATRIX_CROSSTALK_COMPENSATION_UNIT_MACROS_SVH
`define MATRIX_CROSSTALK_COMPENSATION_UNIT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define MCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define MCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/mcc_pkg.sv @@
// Shared constants and types of the matrix crosstalk compensation unit.
// No dependencies; every RTL module of the block imports this package.
package mcc_pkg;

	// Default grid geometry and sample precision.
	localparam int GRID_COLUMNS_DEF = 16;
	localparam int GRID_ROWS_DEF    = 16;
	localparam int SAMPLE_BITS_DEF  = 12;

	// Fixed field widths of the stream words.
	localparam int COL_FIELD_W    = 4;
	localparam int ROW_FIELD_W    = 4;
	localparam int SAMPLE_FIELD_W = 12;
	localparam int LEVEL_W        = 16;
	localparam int DATA_W         = 24;

	// Row sums, denominator and quotient limits.
	localparam int SUM_W  = 16;
	localparam int DEN_W  = 17;
	localparam int DEN_SW = 18;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

	// Configuration registers.
	localparam int REF_W  = 16;
	localparam int GAIN_W = 8;
	localparam logic [REF_W-1:0]  REF_RESET  = 16'd330;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd255;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;
	localparam int REG_SEL_BIT = 2;

	typedef enum logic {
		REG_REFERENCE = 1'b0,
		REG_GAIN      = 1'b1
	} mcc_reg_e;

	// Results are released in bursts of this many cells.
	localparam int CHUNK_MAX = 64;
	localparam int CHUNK_W   = $clog2(CHUNK_MAX);

	// Control from the sequencer to the frame store.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic clear_sums;
	} mcc_store_ctrl_t;

endpackage

@@ hw/rtl/mcc_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
// Depends on mcc_pkg for the denominator width.
`include "matrix_crosstalk_compensation_unit_macros.svh"

module mcc_divider #(
	parameter int NUM_W = mcc_pkg::SAMPLE_BITS_DEF + mcc_pkg::GAIN_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [NUM_W-1:0]         num,
	input  logic [mcc_pkg::DEN_W-1:0] den,
	output logic                     busy,
	output logic                     done,
	output logic [NUM_W-1:0]         quotient
);
	import mcc_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] diff;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		diff    = {1'b0, shifted} - {2'b00, den_q};
	end

	// Step counter: one quotient bit per cycle, done pulses after the last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register; numerator bits shift out as quotient bits enter.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DEN_W+1]) begin
				rem_q <= DEN_W'(diff);
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= DEN_W'(shifted);
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	`MCC_ASSERT_NOW(a_div_no_restart, start, !busy_q, "divider restarted while busy")
	`MCC_ASSERT_NOW(a_div_done_idle, done_q, !busy_q, "divider done while still busy")
	`MCC_ASSERT_NEXT(a_div_finish, busy_q && cnt_q == CNT_W'(1), done_q && !busy_q, "divider missed its last step")

endmodule

@@ hw/rtl/mcc_frame_store.sv @@
// Frame store: sample memory and row-sum memory with the load read-modify-write.
// Depends on mcc_pkg for the control struct and the row-sum width.
`include "matrix_crosstalk_compensation_unit_macros.svh"

module mcc_frame_store #(
	parameter int GRID_COLUMNS = mcc_pkg::GRID_COLUMNS_DEF,
	parameter int GRID_ROWS    = mcc_pkg::GRID_ROWS_DEF,
	parameter int SAMPLE_BITS  = mcc_pkg::SAMPLE_BITS_DEF,
	localparam int ROW_W       = $clog2(GRID_ROWS),
	localparam int CELLS       = GRID_COLUMNS * GRID_ROWS,
	localparam int CELL_AW     = $clog2(CELLS)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mcc_pkg::mcc_store_ctrl_t  ctrl,
	input  logic [ROW_W-1:0]          ld_row,
	input  logic [CELL_AW-1:0]        ld_addr,
	input  logic [SAMPLE_BITS-1:0]    ld_sample,
	input  logic [ROW_W-1:0]          rd_row,
	input  logic [CELL_AW-1:0]        rd_addr,
	output logic                      busy,
	output logic [SAMPLE_BITS-1:0]    rd_sample,
	output logic [mcc_pkg::SUM_W-1:0] rd_row_sum
);
	import mcc_pkg::*;

	localparam int SUMX_W = SUM_W + 1;

	logic [SAMPLE_BITS-1:0] sample_mem [CELLS];
	logic [SUM_W-1:0]       row_sum_mem [GRID_ROWS];
	logic [GRID_ROWS-1:0]   row_valid_q;

	logic                   ld_valid_s1;
	logic [ROW_W-1:0]       row_s1;
	logic [CELL_AW-1:0]     addr_s1;
	logic [SAMPLE_BITS-1:0] smp_s1;

	logic [SUM_W-1:0]       rs_rd_q;
	logic                   rs_vld_q;
	logic [SAMPLE_BITS-1:0] smp_rd_q;

	logic [ROW_W-1:0]       rs_addr;
	logic [SUM_W-1:0]       rs_cur;
	logic [SUMX_W-1:0]      sum_ext;
	logic [SUM_W-1:0]       new_sum;

	// A row that has not been written since the last clear reads as zero.
	always_comb begin
		rs_addr = ctrl.rd_en ? rd_row : ld_row;
		rs_cur  = rs_vld_q ? rs_rd_q : '0;
		sum_ext = {1'b0, rs_cur} + SUMX_W'(smp_s1);
		new_sum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
	end

	// Load stage: hold the accepted word while its row sum is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_valid_s1 <= 1'b0;
		end else begin
			ld_valid_s1 <= ctrl.wr_en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			row_s1  <= ld_row;
			addr_s1 <= ld_addr;
			smp_s1  <= ld_sample;
		end
	end

	// Row-sum valid bits: set on write, all cleared at the end of a frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (ctrl.clear_sums) begin
			row_valid_q <= '0;
		end else if (ld_valid_s1) begin
			row_valid_q[row_s1] <= 1'b1;
		end
	end

	// Row-sum memory: one read port shared by load and correction, one write port.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en || ctrl.rd_en) begin
			rs_rd_q  <= row_sum_mem[rs_addr];
			rs_vld_q <= row_valid_q[rs_addr];
		end
		if (ld_valid_s1) begin
			row_sum_mem[row_s1] <= new_sum;
		end
	end

	// Sample memory: written by the load stage, read during correction.
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			smp_rd_q <= sample_mem[rd_addr];
		end
		if (ld_valid_s1) begin
			sample_mem[addr_s1] <= smp_s1;
		end
	end

	assign busy       = ld_valid_s1;
	assign rd_sample  = smp_rd_q;
	assign rd_row_sum = rs_cur;

	`MCC_ASSERT_NOW(a_store_one_rmw, ld_valid_s1, !ctrl.wr_en, "new word while a row sum update is pending")
	`MCC_ASSERT_NOW(a_store_rd_clean, ctrl.rd_en, !ctrl.wr_en && !ld_valid_s1, "correction read overlaps a load")
	`MCC_ASSERT_NOW(a_store_clear_clean, ctrl.clear_sums, !ld_valid_s1 && !ctrl.wr_en, "row sums cleared during a load")

endmodule

@@ hw/rtl/matrix_crosstalk_compensation_unit.sv @@
// Matrix crosstalk compensation unit, top level.
// Depends on mcc_pkg, mcc_frame_store and mcc_divider.
//
// Usage: samples of one sensor frame enter on the s_axis word stream, one cell
// per word with its column and row; s_axis_tlast marks the last word of a frame.
// Each in-grid word is stored and added to its row sum: the row sum is read,
// then written back, and tready stays low for the write-back cycle. The tlast
// word starts correction: every cell is read back, its level = sample * gain /
// (reference - (row sum - sample)) is computed and sent on m_axis row by row,
// column by column, with m_axis_tlast on the final cell. Results come in bursts
// of 64 cells; the word that ends the frame releases the first burst, each
// further input word releases the next burst and is otherwise ignored. A cell
// with a positive denominator goes through the bit-serial divider; a cell whose
// denominator is not positive skips the divider and is flagged as a fault.
// A full output register with tready low holds the sequence where it is.
// Reset clears all row sums and returns to loading; the sample memory is not
// cleared. The user must write registers over the APB port only while the
// block is idle; the block itself does not enforce this.
`include "matrix_crosstalk_compensation_unit_macros.svh"

module matrix_crosstalk_compensation_unit #(
	parameter int GRID_COLUMNS = mcc_pkg::GRID_COLUMNS_DEF,
	parameter int GRID_ROWS    = mcc_pkg::GRID_ROWS_DEF,
	parameter int SAMPLE_BITS  = mcc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mcc_pkg::APB_AW-1:0]  paddr,
	input  logic [mcc_pkg::APB_DW-1:0]  pwdata,
	output logic [mcc_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// column [3:0], row [7:4], sample [19:8], zero padding [23:20]
	input  logic [mcc_pkg::DATA_W-1:0]  s_axis_tdata,
	input  logic                        s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// out_column [3:0], out_row [7:4], level [23:8]
	output logic [mcc_pkg::DATA_W-1:0]  m_axis_tdata,
	// fault [0]
	output logic [0:0]                  m_axis_tuser,
	output logic                        m_axis_tlast
);
	import mcc_pkg::*;

	localparam int COL_W   = $clog2(GRID_COLUMNS);
	localparam int ROW_W   = $clog2(GRID_ROWS);
	localparam int CELLS   = GRID_COLUMNS * GRID_ROWS;
	localparam int CELL_AW = $clog2(CELLS);
	localparam int NUM_W   = SAMPLE_BITS + GAIN_W;

	typedef enum logic [5:0] {
		ST_LOAD  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_CALC  = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_PUT   = 6'b010000,
		ST_PAUSE = 6'b100000
	} state_t;

	state_t st_q;

	logic [REF_W-1:0]  ref_q;
	logic [GAIN_W-1:0] gain_q;
	logic              cfg_wr;

	logic [COL_FIELD_W-1:0]    in_col;
	logic [ROW_FIELD_W-1:0]    in_row;
	logic [SAMPLE_BITS-1:0]    in_sample;
	logic                      in_range;
	logic                      in_accept;
	logic [ROW_W-1:0]          ld_row_idx;
	logic [COL_W-1:0]          ld_col_idx;
	logic [CELL_AW-1:0]        ld_addr;

	mcc_store_ctrl_t           store_ctrl;
	logic                      store_busy;
	logic [SAMPLE_BITS-1:0]    rd_sample;
	logic [SUM_W-1:0]          rd_row_sum;

	logic [COL_W-1:0]          col_q;
	logic [ROW_W-1:0]          row_q;
	logic [CELL_AW-1:0]        cell_q;
	logic [CHUNK_W-1:0]        chunk_q;
	logic                      col_last;
	logic                      cell_last;

	logic signed [DEN_SW-1:0]  den;
	logic                      den_fault;
	logic [DEN_W-1:0]          den_pos;
	logic [NUM_W-1:0]          num;
	logic                      div_start;
	logic                      div_busy;
	logic                      div_done;
	logic [NUM_W-1:0]          div_quo;

	logic [LEVEL_W-1:0]        res_level_q;
	logic                      res_fault_q;

	logic                      out_load;
	logic                      out_valid_q;
	logic [COL_FIELD_W-1:0]    out_col_q;
	logic [ROW_FIELD_W-1:0]    out_row_q;
	logic [LEVEL_W-1:0]        out_level_q;
	logic                      out_fault_q;
	logic                      out_last_q;

	// Configuration registers; the register is chosen by one address bit.
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q  <= REF_RESET;
			gain_q <= GAIN_RESET;
		end else if (cfg_wr) begin
			if (paddr[REG_SEL_BIT] == REG_GAIN) begin
				gain_q <= GAIN_W'(pwdata);
			end else begin
				ref_q <= REF_W'(pwdata);
			end
		end
	end

	assign prdata = (paddr[REG_SEL_BIT] == REG_GAIN) ? APB_DW'(gain_q) : APB_DW'(ref_q);

	// Input word unpacking and cell address.
	always_comb begin
		in_col     = s_axis_tdata[3:0];
		in_row     = s_axis_tdata[7:4];
		in_sample  = SAMPLE_BITS'(s_axis_tdata[19:8]);
		in_range   = (32'(in_col) < GRID_COLUMNS) && (32'(in_row) < GRID_ROWS);
		ld_row_idx = ROW_W'(in_row);
		ld_col_idx = COL_W'(in_col);
		ld_addr    = CELL_AW'(ld_row_idx * GRID_COLUMNS) + CELL_AW'(ld_col_idx);
	end

	// Handshakes and frame store control.
	always_comb begin
		s_axis_tready = ((st_q == ST_LOAD) && !store_busy) || (st_q == ST_PAUSE);
		in_accept     = s_axis_tvalid && s_axis_tready;
		out_load      = (st_q == ST_PUT) && (!out_valid_q || m_axis_tready);
		col_last      = (32'(col_q) == GRID_COLUMNS - 1);
		cell_last     = col_last && (32'(row_q) == GRID_ROWS - 1);
		store_ctrl.wr_en      = in_accept && (st_q == ST_LOAD) && in_range;
		store_ctrl.rd_en      = (st_q == ST_READ) && !store_busy;
		store_ctrl.clear_sums = out_load && cell_last;
	end

	mcc_frame_store #(
		.GRID_COLUMNS (GRID_COLUMNS),
		.GRID_ROWS    (GRID_ROWS),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (store_ctrl),
		.ld_row     (ld_row_idx),
		.ld_addr    (ld_addr),
		.ld_sample  (in_sample),
		.rd_row     (row_q),
		.rd_addr    (cell_q),
		.busy       (store_busy),
		.rd_sample  (rd_sample),
		.rd_row_sum (rd_row_sum)
	);

	// Denominator and numerator of the correction from the values read back.
	always_comb begin
		den = $signed({2'b00, ref_q}) - $signed({2'b00, rd_row_sum})
			+ $signed(DEN_SW'(rd_sample));
		den_fault = den[DEN_SW-1] || (den == '0);
		den_pos   = DEN_W'(den);
		num       = NUM_W'(rd_sample) * NUM_W'(gain_q);
		div_start = (st_q == ST_CALC) && !den_fault;
	end

	mcc_divider #(
		.NUM_W (NUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (num),
		.den      (den_pos),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Result of the current cell, saturated to the level range.
	always_ff @(posedge clk) begin
		if (st_q == ST_CALC) begin
			res_fault_q <= den_fault;
			if (den_fault) begin
				res_level_q <= LEVEL_MAX;
			end
		end else if (div_done) begin
			res_level_q <= (32'(div_quo) > 32'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(div_quo);
		end
	end

	// Sequencer: loading, then per-cell read, compute, divide and output, with a pause between bursts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_LOAD;
			col_q   <= '0;
			row_q   <= '0;
			cell_q  <= '0;
			chunk_q <= '0;
		end else begin
			case (st_q)
				ST_LOAD: begin
					if (in_accept && s_axis_tlast) begin
						st_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (!store_busy) begin
						st_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					st_q <= den_fault ? ST_PUT : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						st_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (out_load) begin
						if (cell_last) begin
							st_q    <= ST_LOAD;
							col_q   <= '0;
							row_q   <= '0;
							cell_q  <= '0;
							chunk_q <= '0;
						end else begin
							st_q    <= (chunk_q == CHUNK_W'(CHUNK_MAX - 1)) ? ST_PAUSE : ST_READ;
							cell_q  <= cell_q + 1'b1;
							chunk_q <= chunk_q + 1'b1;
							if (col_last) begin
								col_q <= '0;
								row_q <= row_q + 1'b1;
							end else begin
								col_q <= col_q + 1'b1;
							end
						end
					end
				end
				ST_PAUSE: begin
					if (in_accept) begin
						st_q <= ST_READ;
					end
				end
				default: begin
					st_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Output register: takes a new result when empty or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_col_q   <= COL_FIELD_W'(col_q);
			out_row_q   <= ROW_FIELD_W'(row_q);
			out_level_q <= res_level_q;
			out_fault_q <= res_fault_q;
			out_last_q  <= cell_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_level_q, out_row_q, out_col_q};
	assign m_axis_tuser  = out_fault_q;
	assign m_axis_tlast  = out_last_q;

	`MCC_ASSERT_NEXT(a_last_ends_frame, out_load && cell_last,
		st_q == ST_LOAD && m_axis_tlast, "frame did not end after the last cell")
	`MCC_ASSERT_NOW(a_pause_mid_frame, st_q == ST_PAUSE, cell_q != '0 && chunk_q == '0,
		"burst pause outside a burst boundary")
	`MCC_ASSERT_NOW(a_div_positive, div_start, den_pos != '0 && !div_busy,
		"divider started with a bad divisor")
	`MCC_ASSERT_NOW(a_load_idle_cnt, store_ctrl.wr_en, cell_q == '0 && chunk_q == '0,
		"sample stored during correction")

endmodule

@@ tb/tb_matrix_crosstalk_compensation_unit.sv @@
// Self-checking testbench of the matrix crosstalk compensation unit.
// Drives sample frames and register writes, predicts each corrected level and checks it.
// Depends on mcc_pkg and the matrix_crosstalk_compensation_unit RTL.
module tb_matrix_crosstalk_compensation_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import mcc_pkg::*;

	localparam int COLS        = GRID_COLUMNS_DEF;
	localparam int ROWS        = GRID_ROWS_DEF;
	localparam int CELLS       = COLS * ROWS;
	localparam int EXTRA_BURST = CELLS / CHUNK_MAX - 1;
	localparam int CYCLE_LIMIT = 8_000_000;
	localparam logic [15:0] SUM_CEIL = 16'hFFFF;

	typedef struct packed {
		logic [3:0]  col;
		logic [3:0]  row;
		logic [15:0] level;
		logic        fault;
		logic        ends;
	} cell_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	// column [3:0], row [7:4], sample [19:8], zero padding [23:20]
	logic [DATA_W-1:0]   s_axis_tdata = '0;
	logic                s_axis_tlast = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	// out_column [3:0], out_row [7:4], level [23:8]
	logic [DATA_W-1:0]   m_axis_tdata;
	// fault [0]
	logic [0:0]          m_axis_tuser;
	logic                m_axis_tlast;

	// Predictor state: stored frame, row loads, burst position and registers.
	logic [11:0]  cell_reading [ROWS][COLS];
	logic [15:0]  row_load [ROWS] = '{default: '0};
	int unsigned  next_cell = 0;
	bit           correcting = 1'b0;
	logic [15:0]  ref_level_cfg = REF_RESET;
	logic [7:0]   gain_cfg = GAIN_RESET;

	cell_result_t pending_levels [$];
	int unsigned  mismatch_count = 0;
	int unsigned  cycle_count = 0;
	int unsigned  sender_idle_pct = 28;
	int unsigned  receiver_idle_pct = 61;

	matrix_crosstalk_compensation_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit in case the block stops producing or accepting words.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// The receiver stalls at random with the current idle percentage.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	function automatic void note_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("MISMATCH: %s", msg);
	endfunction

	// Corrected level of one cell from the stored frame and the current registers.
	function automatic cell_result_t correct_cell(int unsigned idx);
		cell_result_t res;
		logic [3:0]   c;
		logic [3:0]   r;
		longint       reading;
		longint       load;
		longint       refv;
		longint       den;
		longint       quo;
		c = idx[3:0];
		r = idx[7:4];
		reading = longint'(cell_reading[r][c]);
		load = longint'(row_load[r]);
		refv = longint'(ref_level_cfg);
		den = refv - (load - reading);
		res.col = c;
		res.row = r;
		res.ends = (idx == CELLS - 1);
		// A denominator of zero or less is a fault; large quotients saturate silently.
		if (den <= 0) begin
			res.fault = 1'b1;
			res.level = 16'hFFFF;
		end else begin
			quo = (reading * longint'(gain_cfg)) / den;
			res.fault = 1'b0;
			res.level = (quo > 65535) ? 16'hFFFF : quo[15:0];
		end
		return res;
	endfunction

	// Queue the next burst of cells; the row loads clear after the final cell.
	function automatic void release_burst();
		int n;
		n = 0;
		while (n < CHUNK_MAX && next_cell < CELLS) begin
			pending_levels.push_back(correct_cell(next_cell));
			next_cell++;
			n++;
		end
		if (next_cell >= CELLS) begin
			foreach (row_load[i])
				row_load[i] = '0;
			next_cell = 0;
			correcting = 1'b0;
		end
	endfunction

	// Update the predictor with one accepted input word.
	function automatic void take_word(logic [3:0] c, logic [3:0] r, logic [11:0] reading,
			logic ends);
		logic [16:0] sum;
		// While correcting, a word only releases the next burst.
		if (correcting) begin
			release_burst();
			return;
		end
		cell_reading[r][c] = reading;
		sum = {1'b0, row_load[r]} + 17'(reading);
		row_load[r] = sum[16] ? SUM_CEIL : sum[15:0];
		if (ends) begin
			correcting = 1'b1;
			next_cell = 0;
			release_burst();
		end
	endfunction

	// Predict on accepted input words first, then check accepted result words.
	always @(posedge clk) begin
		cell_result_t got;
		cell_result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				take_word(s_axis_tdata[3:0], s_axis_tdata[7:4], s_axis_tdata[19:8],
					s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				got.col = m_axis_tdata[3:0];
				got.row = m_axis_tdata[7:4];
				got.level = m_axis_tdata[23:8];
				got.fault = m_axis_tuser[0];
				got.ends = m_axis_tlast;
				if (pending_levels.size() == 0) begin
					note_mismatch($sformatf("unexpected word col %0d row %0d level %0d",
						got.col, got.row, got.level));
				end else begin
					want = pending_levels.pop_front();
					if (got !== want)
						note_mismatch($sformatf(
							"exp c%0d r%0d l%0d f%0b t%0b, got c%0d r%0d l%0d f%0b t%0b",
							want.col, want.row, want.level, want.fault, want.ends,
							got.col, got.row, got.level, got.fault, got.ends));
				end
			end
		end
	end

	// Send one input word, with a random gap first, and wait until it is taken.
	task automatic send_word(logic [3:0] c, logic [3:0] r, logic [11:0] reading, logic ends);
		if ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0000, reading, r, c};
		s_axis_tlast <= ends;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Words after the frame end release the remaining bursts; their content is ignored.
	task automatic advance_bursts();
		repeat (EXTRA_BURST)
			send_word(4'($urandom_range(15)), 4'($urandom_range(15)),
				12'($urandom_range(4095)), 1'($urandom_range(1)));
	endtask

	// Hold the sender until every predicted word has come out and the block is idle.
	task automatic wait_for_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// One APB transfer: setup phase, access phase, then idle with psel low.
	task automatic apb_access(logic wr, mcc_reg_e which, logic [APB_DW-1:0] wdata,
			output logic [APB_DW-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= APB_AW'(int'(which) << REG_SEL_BIT);
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write a register, read it back, and update the predictor's copy.
	task automatic write_reg(mcc_reg_e which, int unsigned value);
		logic [APB_DW-1:0] wval;
		logic [APB_DW-1:0] rval;
		wval = (which == REG_REFERENCE) ? (value & 32'hFFFF) : (value & 32'hFF);
		apb_access(1'b1, which, wval, rval);
		apb_access(1'b0, which, '0, rval);
		if (rval !== wval)
			note_mismatch($sformatf("register %s expected %0d, read %0d", which.name(),
				wval, rval));
		if (which == REG_REFERENCE)
			ref_level_cfg = wval[15:0];
		else
			gain_cfg = wval[7:0];
	endtask

	function automatic logic [11:0] pick_reading();
		case ($urandom_range(7))
			0: return 12'd0;
			1: return 12'hFFF;
			default: return 12'($urandom_range(4095));
		endcase
	endfunction

	function automatic int unsigned pick_reference();
		case ($urandom_range(5))
			0: return 0;
			1: return 65535;
			2: return $urandom_range(65535);
			default: return $urandom_range(12000);
		endcase
	endfunction

	function automatic int unsigned pick_gain();
		case ($urandom_range(4))
			0: return 0;
			1: return 255;
			default: return $urandom_range(255);
		endcase
	endfunction

	// Load every cell once under the reset registers so no cell is ever read unwritten.
	task automatic test_full_grid();
		logic [11:0] reading;
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLS; c++) begin
				if (r == 0 && c == 0)
					reading = 12'd0;
				else if (r == ROWS - 1 && c == COLS - 1)
					reading = 12'hFFF;
				else
					reading = pick_reading();
				send_word(4'(c), 4'(r), reading, (r == ROWS - 1 && c == COLS - 1));
			end
		end
		advance_bursts();
	endtask

	// Corner cells with extreme readings; the frame-end word stores its own reading.
	task automatic test_field_extremes();
		wait_for_idle();
		write_reg(REG_REFERENCE, 65535);
		write_reg(REG_GAIN, 255);
		send_word(4'd0, 4'd0, 12'd0, 1'b0);
		send_word(4'd15, 4'd0, 12'hFFF, 1'b0);
		send_word(4'd15, 4'd15, 12'hFFF, 1'b0);
		send_word(4'd0, 4'd15, 12'd1, 1'b1);
		advance_bursts();
	endtask

	// Repeated writes to one cell: the row load saturates and the store keeps the last one.
	task automatic test_row_saturation();
		wait_for_idle();
		write_reg(REG_REFERENCE, 65535);
		write_reg(REG_GAIN, 255);
		repeat (17)
			send_word(4'd9, 4'd5, 12'hFFF, 1'b0);
		send_word(4'd9, 4'd5, 12'd7, 1'b1);
		advance_bursts();
	endtask

	// Zero denominator with zero registers, then a quotient far above the level range.
	task automatic test_denominator_edges();
		wait_for_idle();
		write_reg(REG_REFERENCE, 0);
		write_reg(REG_GAIN, 0);
		send_word(4'd2, 4'd3, 12'd100, 1'b1);
		advance_bursts();
		wait_for_idle();
		write_reg(REG_REFERENCE, 1);
		write_reg(REG_GAIN, 255);
		send_word(4'd4, 4'd7, 12'hFFF, 1'b1);
		advance_bursts();
	endtask

	// Random frames, mostly short, some on a single row, with registers changed between.
	task automatic test_random_frames(int unsigned n_words, int unsigned send_pct,
			int unsigned recv_pct);
		int unsigned loaded;
		int unsigned len;
		bit          one_row;
		logic [3:0]  focus_row;
		sender_idle_pct = send_pct;
		receiver_idle_pct = recv_pct;
		loaded = 0;
		while (loaded < n_words) begin
			if ($urandom_range(2) == 0) begin
				wait_for_idle();
				write_reg(REG_REFERENCE, pick_reference());
				write_reg(REG_GAIN, pick_gain());
			end
			len = ($urandom_range(7) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 10);
			one_row = ($urandom_range(3) == 0);
			focus_row = 4'($urandom_range(15));
			for (int unsigned i = 0; i < len; i++)
				send_word(4'($urandom_range(15)), one_row ? focus_row : 4'($urandom_range(15)),
					pick_reading(), (i == len - 1));
			loaded += len;
			advance_bursts();
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_full_grid();
		test_field_extremes();
		test_row_saturation();
		test_denominator_edges();
		test_random_frames(57, 28, 61);
		test_random_frames(57, 61, 28);
		test_random_frames(56, 0, 0);
		wait_for_idle();
		repeat (60) @(posedge clk);
		if (mismatch_count == 0 && pending_levels.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
